### rtl/flvdmx_pkg.sv
// Types, constants and helpers shared by the FLV tag demultiplexer files.
package flvdmx_pkg;

  // Parse phases of the byte stream.
  typedef enum logic [2:0] {
    PH_FILE   = 3'd0,
    PH_PTS    = 3'd1,
    PH_TAGHDR = 3'd2,
    PH_FIRST  = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  // Tag type byte values.
  localparam logic [7:0] TYPE_AUDIO  = 8'h08;
  localparam logic [7:0] TYPE_VIDEO  = 8'h09;
  localparam logic [7:0] TYPE_SCRIPT = 8'h12;

  // Tag kind codes on the result.
  localparam logic [1:0] KIND_AUDIO   = 2'd0;
  localparam logic [1:0] KIND_VIDEO   = 2'd1;
  localparam logic [1:0] KIND_SCRIPT  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // Route codes on the result.
  localparam logic [1:0] ROUTE_NONE  = 2'd0;
  localparam logic [1:0] ROUTE_AUDIO = 2'd1;
  localparam logic [1:0] ROUTE_VIDEO = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_AUDIO_ENABLE = 1'b0;
  localparam logic CFG_VIDEO_ENABLE = 1'b1;

  // Field lengths in bytes, and last byte indexes of the size and time fields.
  localparam int FILE_HDR_LEN = 9;
  localparam int PTS_LEN      = 4;
  localparam int TAG_HDR_LEN  = 11;
  localparam int SIZE_LAST    = 3;
  localparam int TIME_LAST    = 6;
  // Flags byte position in the file header, and its replacement value.
  localparam int          FLAGS_POS   = 4;
  localparam logic [7:0]  FLAGS_VIDEO = 8'h01;
  // Beats of a video start burst: file header, four zero bytes, type byte.
  localparam int BURST_LEN  = FILE_HDR_LEN + PTS_LEN + 1;
  localparam int BEAT_W     = $clog2(BURST_LEN);
  localparam int HDR_IDX_W  = $clog2(FILE_HDR_LEN);

  // One queued result; a burst entry expands into BURST_LEN transfers.
  typedef struct packed {
    logic [1:0]  route;
    logic [7:0]  data;
    logic        burst;
    logic        info_valid;
    logic [3:0]  info_high;
    logic [3:0]  info_low;
    logic [1:0]  kind;
    logic [23:0] size;
    logic [23:0] stamp;
    logic        err;
  } desc_t;

  function automatic logic [1:0] kind_of(input logic [7:0] t);
    logic [1:0] k;
    case (t)
      TYPE_AUDIO:  k = KIND_AUDIO;
      TYPE_VIDEO:  k = KIND_VIDEO;
      TYPE_SCRIPT: k = KIND_SCRIPT;
      default:     k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

### rtl/flv_tag_demultiplexer_unit.sv
// FLV tag demultiplexer: byte-serial parser with audio and video routing.
//
// Takes one byte of an FLV file per input transfer and accepts a byte in every
// cycle while the queue has room. Each byte is parsed in the cycle it is accepted
// and leaves a result entry in a two-entry queue. Most bytes give one output
// transfer. The type byte of the first routed video tag gives fourteen: the
// stored file header with its flags byte set to 1, four zero bytes, then the
// type byte itself, one per cycle unless stalled; the output sequencer then
// holds the queue head, and input keeps flowing until the two queue entries
// are full. Sustained rate is one byte per cycle unless stalled, set by the
// output sequencer taking one transfer a cycle. last_o marks the final
// transfer caused by one input byte. An unknown tag type sets format_error_o
// and every later byte gives one empty transfer until reset. Configuration
// writes are always accepted; write them only while the block is idle.
module flv_tag_demultiplexer_unit
  import flvdmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_route_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  tag_kind_o,
  output logic        info_valid_o,
  output logic [23:0] payload_size_o,
  output logic [23:0] tag_time_o,
  output logic [3:0]  info_high_o,
  output logic [3:0]  info_low_o,
  output logic        format_error_o
);

  // Configuration registers
  logic audio_en_q, video_en_q;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [23:0] idx_q, idx_d;
  logic [7:0]  type_q, type_d;
  logic [23:0] size_q, size_d;
  logic [23:0] time_q, time_d;
  logic        started_q, started_d;
  logic        trailer_q, trailer_d;
  logic        halted_q, halted_d;
  logic        store_we;
  logic [7:0]  hdr_store [FILE_HDR_LEN];

  // Result queue and output sequencer
  desc_t             desc_d;
  desc_t             slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic [BEAT_W-1:0] beat_q;
  desc_t             head;
  logic              in_fire, out_fire, pop;
  logic [1:0]        type_kind;
  logic [1:0]        cur_kind;
  logic [23:0]       idx_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q != 2'd2);
  assign in_fire     = in_valid_i & in_ready_o;
  assign type_kind   = kind_of(data_byte_i);
  assign cur_kind    = kind_of(type_q);
  assign idx_inc     = idx_q + 24'd1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_en_q <= 1'b1;
      video_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AUDIO_ENABLE: audio_en_q <= cfg_data_i;
        CFG_VIDEO_ENABLE: video_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next parser state for an accepted byte
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    type_d    = type_q;
    size_d    = size_q;
    time_d    = time_q;
    started_d = started_q;
    trailer_d = trailer_q;
    halted_d  = halted_q;
    store_we  = 1'b0;
    if (in_fire && !halted_q) begin
      unique case (phase_q)
        PH_FILE: begin
          // keep a copy of the file header for the video route
          store_we = 1'b1;
          if (idx_q == 24'(FILE_HDR_LEN - 1)) begin
            phase_d = PH_PTS;
            idx_d   = '0;
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_PTS: begin
          if (idx_q == 24'(PTS_LEN - 1)) begin
            phase_d   = PH_TAGHDR;
            idx_d     = '0;
            trailer_d = 1'b0;
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_TAGHDR: begin
          if (idx_q == '0) begin
            type_d = data_byte_i;
            case (type_kind)
              KIND_AUDIO:  trailer_d = 1'b0;
              KIND_VIDEO: begin
                trailer_d = video_en_q;
                if (video_en_q) started_d = 1'b1;
              end
              KIND_SCRIPT: trailer_d = video_en_q & started_q;
              default: begin
                halted_d  = 1'b1;
                trailer_d = 1'b0;
              end
            endcase
          end else if (idx_q <= 24'(SIZE_LAST)) begin
            size_d = {size_q[15:0], data_byte_i};
          end else if (idx_q <= 24'(TIME_LAST)) begin
            time_d = {time_q[15:0], data_byte_i};
          end
          // hold the index on an unknown type: the block halts there
          if (!(idx_q == '0 && type_kind == KIND_UNKNOWN)) begin
            if (idx_q == 24'(TAG_HDR_LEN - 1)) begin
              idx_d   = '0;
              phase_d = (size_q != '0) ? PH_FIRST : PH_PTS;
            end else begin
              idx_d = idx_inc;
            end
          end
        end
        PH_FIRST: begin
          if (size_q <= 24'd1) begin
            phase_d = PH_PTS;
            idx_d   = '0;
          end else begin
            phase_d = PH_DATA;
            idx_d   = 24'd1;
          end
        end
        PH_DATA: begin
          if (idx_inc >= size_q) begin
            phase_d = PH_PTS;
            idx_d   = '0;
          end else begin
            idx_d = idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Result entry for the byte on the input
  always_comb begin
    desc_d            = '0;
    desc_d.kind       = kind_of(type_d);
    desc_d.size       = size_d;
    desc_d.stamp      = time_d;
    desc_d.err        = halted_d;
    if (!halted_q) begin
      unique case (phase_q)
        PH_PTS: begin
          if (trailer_q) begin
            desc_d.route = ROUTE_VIDEO;
            desc_d.data  = data_byte_i;
          end
        end
        PH_TAGHDR: begin
          if (trailer_d) begin
            desc_d.route = ROUTE_VIDEO;
            desc_d.data  = data_byte_i;
          end
          desc_d.burst = (idx_q == '0) && (type_kind == KIND_VIDEO) &&
                         video_en_q && !started_q;
        end
        PH_FIRST: begin
          if (cur_kind == KIND_AUDIO || cur_kind == KIND_VIDEO) begin
            desc_d.info_valid = 1'b1;
            desc_d.info_high  = data_byte_i[7:4];
            desc_d.info_low   = data_byte_i[3:0];
          end
          if (cur_kind != KIND_AUDIO && trailer_q) begin
            desc_d.route = ROUTE_VIDEO;
            desc_d.data  = data_byte_i;
          end
        end
        PH_DATA: begin
          if (cur_kind == KIND_AUDIO) begin
            if (audio_en_q) begin
              desc_d.route = ROUTE_AUDIO;
              desc_d.data  = data_byte_i;
            end
          end else if (trailer_q) begin
            desc_d.route = ROUTE_VIDEO;
            desc_d.data  = data_byte_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FILE;
      idx_q     <= '0;
      type_q    <= '0;
      size_q    <= '0;
      time_q    <= '0;
      started_q <= 1'b0;
      trailer_q <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      type_q    <= type_d;
      size_q    <= size_d;
      time_q    <= time_d;
      started_q <= started_d;
      trailer_q <= trailer_d;
      halted_q  <= halted_d;
    end
  end

  // File header copy: every entry is written before the burst reads it
  always_ff @(posedge clk_i) begin
    if (store_we) hdr_store[idx_q[HDR_IDX_W-1:0]] <= data_byte_i;
  end

  // Result queue: push on an input transfer, pop on the last output beat
  assign head     = slot_q[rd_ptr_q];
  assign out_fire = out_valid_o & out_ready_i;
  assign pop      = out_fire & last_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) slot_q[wr_ptr_q] <= desc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      beat_q   <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= ~wr_ptr_q;
      if (pop)     rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, in_fire} - {1'b0, pop};
      if (pop) begin
        beat_q <= '0;
      end else if (out_fire) begin
        beat_q <= beat_q + BEAT_W'(1);
      end
    end
  end

  // Output beat: a burst walks the header copy, the zero bytes, then the type
  always_comb begin
    out_route_o = head.route;
    out_byte_o  = head.data;
    last_o      = 1'b1;
    if (head.burst) begin
      last_o = (beat_q == BEAT_W'(BURST_LEN - 1));
      if (beat_q < BEAT_W'(FILE_HDR_LEN)) begin
        out_byte_o = (beat_q == BEAT_W'(FLAGS_POS)) ? FLAGS_VIDEO
                                                    : hdr_store[beat_q[HDR_IDX_W-1:0]];
      end else if (!last_o) begin
        out_byte_o = '0;
      end
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign tag_kind_o     = head.kind;
  assign info_valid_o   = head.info_valid;
  assign payload_size_o = head.size;
  assign tag_time_o     = head.stamp;
  assign info_high_o    = head.info_high;
  assign info_low_o     = head.info_low;
  assign format_error_o = head.err;

endmodule

### rtl/flvdmx_checker.sv
// Port checker for the FLV tag demultiplexer and its bind statement.
module flvdmx_checker
  import flvdmx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  out_route_o,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic        info_valid_o,
  input logic [3:0]  info_high_o,
  input logic [3:0]  info_low_o,
  input logic        format_error_o
);

  logic err_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && format_error_o) begin
      err_seen_q <= 1'b1;
    end
  end

  // once halted, every transfer is a single empty one flagged as an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q |->
      format_error_o && last_o && out_route_o == ROUTE_NONE)
    else $error("transfer after format error is not an empty error result");

  // an empty route carries a zero byte and never the unused route code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_route_o != 2'd3 &&
      (out_route_o != ROUTE_NONE || out_byte_o == 8'd0))
    else $error("bad route or stray byte on empty route");

  // stream info only on a single-transfer result off the audio route, zero otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (info_valid_o ? (last_o && out_route_o != ROUTE_AUDIO)
                                  : (info_high_o == 4'd0 && info_low_o == 4'd0)))
    else $error("stream info fields inconsistent");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(out_route_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind flv_tag_demultiplexer_unit flvdmx_checker u_flvdmx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_route_o    (out_route_o),
  .out_byte_o     (out_byte_o),
  .last_o         (last_o),
  .info_valid_o   (info_valid_o),
  .info_high_o    (info_high_o),
  .info_low_o     (info_low_o),
  .format_error_o (format_error_o)
);
